// ===== rtl/trsc_pkg.sv =====
// trsc_pkg: shared types, constants and codes for the three-rotor cipher
// used by every module of the block but trsc_fifo; depends on nothing
package trsc_pkg;

   // default alphabet size and fixed field widths
   localparam int ALPHABET_SIZE_DEF = 26;
   localparam int LETTER_W          = 5;
   localparam int CHAR_W            = 8;
   localparam int NUM_DIGITS        = 3;

   // back pipeline: plug, rotors 1-3, reflector, inverse rotors 3-1, plug
   localparam int NUM_STAGES = 9;

   // chars the block can hold: queue, pipeline stages and output buffer
   localparam int PIPE_CAPACITY = 2 + NUM_STAGES + 2;

   // stream widths
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 8;

   // ascii landmarks
   localparam logic [CHAR_W-1:0] UPPER_A  = 8'd65;
   localparam logic [CHAR_W-1:0] UPPER_Z  = 8'd90;
   localparam logic [CHAR_W-1:0] LOWER_A  = 8'd97;
   localparam logic [CHAR_W-1:0] LOWER_Z  = 8'd122;
   localparam logic [CHAR_W-1:0] CASE_GAP = 8'd32;

   typedef enum logic {
      MODE_CIPHER = 1'b0,
      MODE_LOAD   = 1'b1
   } trsc_mode_type;

   typedef enum logic [2:0] {
      TBL_ROTOR_ONE   = 3'd0,
      TBL_ROTOR_TWO   = 3'd1,
      TBL_ROTOR_THREE = 3'd2,
      TBL_REFLECTOR   = 3'd3,
      TBL_PLUGBOARD   = 3'd4
   } trsc_table_type;

   typedef logic [LETTER_W-1:0] trsc_letter_type;

   // classified item, front to back
   typedef struct packed {
      logic                                  is_load;
      trsc_table_type                        table_sel;
      trsc_letter_type                       entry;
      logic                                  in_alpha;
      logic                                  is_lower;
      trsc_letter_type                       letter;
      logic [CHAR_W-1:0]                     char_byte;
      trsc_letter_type [NUM_DIGITS-1:0]      digits;
   } trsc_item_type;

   // one char in flight through the back pipeline
   typedef struct packed {
      logic                                  in_alpha;
      logic                                  is_lower;
      logic [CHAR_W-1:0]                     char_byte;
      trsc_letter_type                       x;
      trsc_letter_type [NUM_DIGITS-1:0]      digits;
   } trsc_stage_type;

endpackage

// ===== rtl/trsc_fifo.sv =====
// trsc_fifo: two-entry register fifo with valid/ready on both sides
// used for the front-to-back queue and the result buffer; no package needed
module trsc_fifo #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push;
   logic             pop;

   // status and head
   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/trsc_front.sv =====
// trsc_front: accepts beats, classifies them, runs the position odometer
// depends on trsc_pkg
module trsc_front #(
   parameter int ALPHABET_SIZE = trsc_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    mode,
   input  logic [2:0]              table_select,
   input  logic [4:0]              entry_index,
   input  logic [7:0]              char_value,
   output logic                    push_valid,
   input  logic                    push_ready,
   output trsc_pkg::trsc_item_type push_item
);
   import trsc_pkg::*;

   localparam int SIZE_W = LETTER_W + 1;
   localparam logic [SIZE_W-1:0] SIZE = SIZE_W'(ALPHABET_SIZE);

   logic                             is_upper;
   logic                             is_lower;
   logic                             in_alpha;
   logic                             load_ok;
   logic                             is_cipher;
   logic                             accept;
   logic [CHAR_W-1:0]                letter_wide;
   trsc_letter_type                  letter;
   trsc_letter_type [NUM_DIGITS-1:0] digit_ff;
   trsc_letter_type [NUM_DIGITS-1:0] digit_in;
   logic                             carry;

   assign is_cipher = (mode == MODE_CIPHER);
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   // letter detection and index
   always_comb begin
      is_upper = char_value inside {[UPPER_A:UPPER_Z]};
      is_lower = char_value inside {[LOWER_A:LOWER_Z]};
      if (is_upper) begin
         letter_wide = char_value - UPPER_A;
      end else if (is_lower) begin
         letter_wide = char_value - LOWER_A;
      end else begin
         letter_wide = '0;
      end
      letter   = letter_wide[LETTER_W-1:0];
      in_alpha = (is_upper || is_lower) && ({1'b0, letter} < SIZE);
      load_ok  = in_alpha && ({1'b0, entry_index} < SIZE)
                 && (table_select <= TBL_PLUGBOARD);
   end

   // bad loads are dropped here, everything else goes to the queue
   assign push_valid = req_valid && (is_cipher || load_ok);

   always_comb begin
      push_item.is_load   = !is_cipher;
      push_item.table_sel = trsc_table_type'(table_select);
      push_item.entry     = entry_index;
      push_item.in_alpha  = in_alpha;
      push_item.is_lower  = is_lower;
      push_item.letter    = in_alpha ? letter : '0;
      push_item.char_byte = char_value;
      push_item.digits    = digit_ff;
   end

   // odometer increment, digit 0 fastest
   always_comb begin
      digit_in = digit_ff;
      carry    = 1'b1;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         if (carry) begin
            if (({1'b0, digit_ff[k]} + SIZE_W'(1)) >= SIZE) begin
               digit_in[k] = '0;
            end else begin
               digit_in[k] = digit_ff[k] + LETTER_W'(1);
               carry       = 1'b0;
            end
         end
      end
   end

   // every accepted char beat steps the odometer
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else if (accept && is_cipher) begin
         digit_ff <= digit_in;
      end
   end

endmodule

// ===== rtl/trsc_back.sv =====
// trsc_back: wiring tables and the nine-stage lookup pipeline
// depends on trsc_pkg; fed from the front queue, drives the result buffer
module trsc_back #(
   parameter int ALPHABET_SIZE = trsc_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   output logic                          head_ready,
   input  trsc_pkg::trsc_item_type       head_item,
   output logic                          res_valid,
   input  logic                          res_ready,
   output logic [trsc_pkg::CHAR_W-1:0]   res_data
);
   import trsc_pkg::*;

   localparam int IDX_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int SIZE_W = LETTER_W + 1;
   localparam logic [SIZE_W-1:0] SIZE = SIZE_W'(ALPHABET_SIZE);
   localparam int LAST = NUM_STAGES - 1;

   // wiring tables
   trsc_letter_type rot1_fwd_ff [ALPHABET_SIZE];
   trsc_letter_type rot2_fwd_ff [ALPHABET_SIZE];
   trsc_letter_type rot3_fwd_ff [ALPHABET_SIZE];
   trsc_letter_type rot1_inv_ff [ALPHABET_SIZE];
   trsc_letter_type rot2_inv_ff [ALPHABET_SIZE];
   trsc_letter_type rot3_inv_ff [ALPHABET_SIZE];
   trsc_letter_type refl_ff     [ALPHABET_SIZE];
   trsc_letter_type plug_mem_ff [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] plug_valid_ff;

   trsc_stage_type          stage_ff [NUM_STAGES];
   trsc_stage_type          stage_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]   stage_valid_ff;
   trsc_stage_type          head_stage;

   logic            adv;
   logic            take_char;
   logic            take_load;
   logic            pipe_empty;
   logic [IDX_W-1:0] plug_in_idx;
   logic [IDX_W-1:0] plug_out_idx;
   trsc_letter_type rot1_out;
   trsc_letter_type rot2_out;
   trsc_letter_type rot3_out;
   trsc_letter_type refl_out;
   trsc_letter_type rot3i_out;
   trsc_letter_type rot2i_out;
   trsc_letter_type rot1i_out;

   function automatic logic [IDX_W-1:0] tab_idx(input trsc_letter_type a);
      return a[IDX_W-1:0];
   endfunction

   function automatic trsc_letter_type add_mod(input trsc_letter_type a,
                                               input trsc_letter_type b);
      logic [SIZE_W-1:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= SIZE) begin
         sum = sum - SIZE;
      end
      return sum[LETTER_W-1:0];
   endfunction

   function automatic trsc_letter_type sub_mod(input trsc_letter_type a,
                                               input trsc_letter_type b);
      logic [SIZE_W-1:0] diff;
      if (a >= b) begin
         diff = {1'b0, a} - {1'b0, b};
      end else begin
         diff = {1'b0, a} + SIZE - {1'b0, b};
      end
      return diff[LETTER_W-1:0];
   endfunction

   // flow control: loads wait until no char is in flight
   assign adv        = !stage_valid_ff[LAST] || res_ready;
   assign pipe_empty = (stage_valid_ff == '0);
   assign head_ready = head_item.is_load ? pipe_empty : adv;
   assign take_char  = head_valid && !head_item.is_load && adv;
   assign take_load  = head_valid && head_item.is_load && pipe_empty;

   always_comb begin
      head_stage.in_alpha  = head_item.in_alpha;
      head_stage.is_lower  = head_item.is_lower;
      head_stage.char_byte = head_item.char_byte;
      head_stage.x         = head_item.letter;
      head_stage.digits    = head_item.digits;
   end

   // rotor, reflector and inverse steps, one per stage
   always_comb begin
      rot1_out  = rot1_fwd_ff[tab_idx(add_mod(stage_ff[0].x, stage_ff[0].digits[0]))];
      rot2_out  = rot2_fwd_ff[tab_idx(add_mod(stage_ff[1].x, stage_ff[1].digits[1]))];
      rot3_out  = rot3_fwd_ff[tab_idx(add_mod(stage_ff[2].x, stage_ff[2].digits[2]))];
      refl_out  = refl_ff[tab_idx(stage_ff[3].x)];
      rot3i_out = sub_mod(rot3_inv_ff[tab_idx(stage_ff[4].x)], stage_ff[4].digits[2]);
      rot2i_out = sub_mod(rot2_inv_ff[tab_idx(stage_ff[5].x)], stage_ff[5].digits[1]);
      rot1i_out = sub_mod(rot1_inv_ff[tab_idx(stage_ff[6].x)], stage_ff[6].digits[0]);
   end

   assign plug_in_idx  = tab_idx(head_stage.x);
   assign plug_out_idx = tab_idx(stage_ff[7].x);

   // next stage payload, plugboard read on entry and exit
   always_comb begin
      for (int k = 1; k < NUM_STAGES; k++) begin
         stage_in[k] = stage_ff[k-1];
      end
      stage_in[0]   = head_stage;
      stage_in[0].x = plug_valid_ff[plug_in_idx] ? plug_mem_ff[plug_in_idx]
                                                 : head_stage.x;
      stage_in[1].x = rot1_out;
      stage_in[2].x = rot2_out;
      stage_in[3].x = rot3_out;
      stage_in[4].x = refl_out;
      stage_in[5].x = rot3i_out;
      stage_in[6].x = rot2i_out;
      stage_in[7].x = rot1i_out;
      stage_in[8].x = plug_valid_ff[plug_out_idx] ? plug_mem_ff[plug_out_idx]
                                                  : stage_ff[7].x;
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else if (adv) begin
         stage_valid_ff <= {stage_valid_ff[NUM_STAGES-2:0], take_char};
      end
   end

   // table loads; a rotor write also fills its inverse
   always_ff @(posedge clock) begin
      if (take_load) begin
         case (head_item.table_sel)
            TBL_ROTOR_ONE: begin
               rot1_fwd_ff[tab_idx(head_item.entry)]  <= head_item.letter;
               rot1_inv_ff[tab_idx(head_item.letter)] <= head_item.entry;
            end
            TBL_ROTOR_TWO: begin
               rot2_fwd_ff[tab_idx(head_item.entry)]  <= head_item.letter;
               rot2_inv_ff[tab_idx(head_item.letter)] <= head_item.entry;
            end
            TBL_ROTOR_THREE: begin
               rot3_fwd_ff[tab_idx(head_item.entry)]  <= head_item.letter;
               rot3_inv_ff[tab_idx(head_item.letter)] <= head_item.entry;
            end
            TBL_REFLECTOR: begin
               refl_ff[tab_idx(head_item.entry)] <= head_item.letter;
            end
            TBL_PLUGBOARD: begin
               plug_mem_ff[tab_idx(head_item.entry)] <= head_item.letter;
            end
            default: begin
            end
         endcase
      end
   end

   // plugboard entries read as identity until written
   always_ff @(posedge clock) begin
      if (reset) begin
         plug_valid_ff <= '0;
      end else if (take_load && (head_item.table_sel == TBL_PLUGBOARD)) begin
         plug_valid_ff[tab_idx(head_item.entry)] <= 1'b1;
      end
   end

   // back to ascii, case restored
   assign res_valid = stage_valid_ff[LAST];
   always_comb begin
      if (stage_ff[LAST].in_alpha) begin
         res_data = UPPER_A + {{(CHAR_W-LETTER_W){1'b0}}, stage_ff[LAST].x}
                    + (stage_ff[LAST].is_lower ? CASE_GAP : '0);
      end else begin
         res_data = stage_ff[LAST].char_byte;
      end
   end

endmodule

// ===== rtl/three_rotor_substitution_cipher.sv =====
// Three-rotor substitution cipher over ascii bytes.
// Input stream (req_*): each beat either loads one wiring entry (tuser mode
// bit set) into rotor 1-3, the reflector or the plugboard, or enciphers one
// byte. Result stream (rsp_*): one byte per encipher beat, none per load.
// Letters keep their case, other bytes pass unchanged; every encipher beat
// steps the three-digit rotor odometer.
// Path: a char accepted on req_* passes the front queue register, the nine
// lookup stages and the result buffer before it shows on rsp_tvalid.
// Throughput: one char per cycle while rsp_tready is high. A load beat waits
// in the queue until the chars ahead of it have left the lookup pipeline,
// and a low rsp_tready can keep them there.
// Reset: odometer to zero, plugboard to identity, all queues empty; rotor
// and reflector tables hold nothing defined until loaded.
// When rsp_tready is low the result buffer holds two bytes, the pipeline
// then freezes, and the two-entry front queue fills before req_tready drops.
// depends on trsc_pkg, trsc_front, trsc_fifo, trsc_back
module three_rotor_substitution_cipher #(
   parameter int ALPHABET_SIZE = trsc_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index [4:0], char_value [12:5], zero [15:13]
   input  logic [trsc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // mode [0], table_select [3:1]
   input  logic [trsc_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_char [7:0]
   output logic [trsc_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import trsc_pkg::*;

   localparam int ITEM_W = $bits(trsc_item_type);

   trsc_item_type     push_item;
   trsc_item_type     head_item;
   logic [ITEM_W-1:0] head_bits;
   logic              push_valid;
   logic              push_ready;
   logic              head_valid;
   logic              head_ready;
   logic              res_valid;
   logic              res_ready;
   logic [CHAR_W-1:0] res_data;

   // accept and classify
   trsc_front #(
      .ALPHABET_SIZE(ALPHABET_SIZE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .mode        (req_tuser[0]),
      .table_select(req_tuser[3:1]),
      .entry_index (req_tdata[4:0]),
      .char_value  (req_tdata[12:5]),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   // front to back queue
   trsc_fifo #(
      .WIDTH(ITEM_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (push_valid),
      .in_ready (push_ready),
      .in_data  (push_item),
      .out_valid(head_valid),
      .out_ready(head_ready),
      .out_data (head_bits)
   );

   assign head_item = trsc_item_type'(head_bits);

   // tables and lookup pipeline
   trsc_back #(
      .ALPHABET_SIZE(ALPHABET_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_ready(head_ready),
      .head_item (head_item),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   // result buffer
   trsc_fifo #(
      .WIDTH(RSP_TDATA_W)
   ) u_result (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_ready (res_ready),
      .in_data  (res_data),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (rsp_tdata)
   );

endmodule

// ===== rtl/trsc_checker.sv =====
// trsc_checker: port-level checks for the cipher top level, plus its bind
// depends on trsc_pkg; sees only the top-level ports
module trsc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [trsc_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [trsc_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import trsc_pkg::*;

   localparam int PEND_W = $clog2(PIPE_CAPACITY + 1);
   localparam logic [PEND_W-1:0] CAP = PEND_W'(PIPE_CAPACITY);

   logic [PEND_W-1:0] pend_ff;
   logic              char_in;
   logic              char_out;

   assign char_in  = req_tvalid && req_tready && (req_tuser[0] == MODE_CIPHER);
   assign char_out = rsp_tvalid && rsp_tready;

   // chars accepted and not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (char_in && !char_out) begin
         pend_ff <= pend_ff + PEND_W'(1);
      end else if (char_out && !char_in) begin
         pend_ff <= pend_ff - PEND_W'(1);
      end
   end

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // no result without a char beat behind it
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != '0)
      else $error("result with no pending char");

   // with every slot holding a char, the input must push back
   assert property (@(posedge clock) disable iff (reset)
      pend_ff == CAP |-> !req_tready)
      else $error("input ready with block full of chars");

   // nothing left over after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind three_rotor_substitution_cipher trsc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
